/* src/cle_pkg.sv */
// Package for the command line editor: character codes, result kinds,
// microcode word format and the microcode ROM itself.
// No dependencies.
package cle_pkg;

   localparam int LINE_BUFFER_SIZE_DEF = 64;
   localparam int MAX_ARGS_DEF         = 8;

   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_NUL   = 8'h00;

   typedef enum logic [1:0] {
      KIND_TX,
      KIND_ARG,
      KIND_DONE
   } kind_type;

   typedef enum logic [1:0] {
      MODE_SEEK,
      MODE_WORD,
      MODE_QUOTE
   } mode_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_FETCH,
      OP_STORE,
      OP_EMIT_CHAR,
      OP_EMIT_CONST,
      OP_DEC_EMIT,
      OP_SCAN,
      OP_TAIL,
      OP_DONE
   } op_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_IS_CR,
      COND_IS_BS,
      COND_IS_LF,
      COND_FULL,
      COND_ECHO_OFF,
      COND_EMPTY,
      COND_AT_END,
      COND_MORE
   } cond_type;

   localparam int PC_W = 5;

   localparam logic [PC_W-1:0] ST_FETCH     = 5'd0;
   localparam logic [PC_W-1:0] ST_CHK_CR    = 5'd1;
   localparam logic [PC_W-1:0] ST_CHK_BS    = 5'd2;
   localparam logic [PC_W-1:0] ST_CHK_LF    = 5'd3;
   localparam logic [PC_W-1:0] ST_CHK_FULL  = 5'd4;
   localparam logic [PC_W-1:0] ST_STORE     = 5'd5;
   localparam logic [PC_W-1:0] ST_ECHO      = 5'd6;
   localparam logic [PC_W-1:0] ST_CR_EMPTY  = 5'd7;
   localparam logic [PC_W-1:0] ST_TX_CR     = 5'd8;
   localparam logic [PC_W-1:0] ST_TX_LF     = 5'd9;
   localparam logic [PC_W-1:0] ST_SCAN_RD   = 5'd10;
   localparam logic [PC_W-1:0] ST_SCAN      = 5'd11;
   localparam logic [PC_W-1:0] ST_TAIL      = 5'd12;
   localparam logic [PC_W-1:0] ST_DONE      = 5'd13;
   localparam logic [PC_W-1:0] ST_BS_EMPTY  = 5'd14;
   localparam logic [PC_W-1:0] ST_BS_1      = 5'd15;
   localparam logic [PC_W-1:0] ST_BS_SP     = 5'd16;
   localparam logic [PC_W-1:0] ST_BS_2      = 5'd17;

   typedef struct packed {
      op_type          op;
      logic [7:0]      tx;
      logic            last;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic no_req;
      logic is_cr;
      logic is_bs;
      logic is_lf;
      logic full;
      logic echo_off;
      logic empty;
      logic at_end;
      logic more;
      logic hold;
   } flag_type;

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = '{op: OP_NOP, tx: CH_NUL, last: 1'b0, cond: COND_NEVER, target: ST_FETCH};
      unique case (pc)
         ST_FETCH: begin
            w.op = OP_FETCH; w.cond = COND_NO_REQ; w.target = ST_FETCH;
         end
         ST_CHK_CR: begin
            w.cond = COND_IS_CR; w.target = ST_CR_EMPTY;
         end
         ST_CHK_BS: begin
            w.cond = COND_IS_BS; w.target = ST_BS_EMPTY;
         end
         ST_CHK_LF: begin
            w.cond = COND_IS_LF; w.target = ST_FETCH;
         end
         ST_CHK_FULL: begin
            w.cond = COND_FULL; w.target = ST_FETCH;
         end
         ST_STORE: begin
            w.op = OP_STORE; w.cond = COND_ECHO_OFF; w.target = ST_FETCH;
         end
         ST_ECHO: begin
            w.op = OP_EMIT_CHAR; w.last = 1'b1; w.cond = COND_ALWAYS; w.target = ST_FETCH;
         end
         ST_CR_EMPTY: begin
            w.cond = COND_EMPTY; w.target = ST_DONE;
         end
         ST_TX_CR: begin
            w.op = OP_EMIT_CONST; w.tx = CH_CR;
         end
         ST_TX_LF: begin
            w.op = OP_EMIT_CONST; w.tx = CH_LF;
         end
         ST_SCAN_RD: begin
            w.cond = COND_AT_END; w.target = ST_TAIL;
         end
         ST_SCAN: begin
            w.op = OP_SCAN; w.cond = COND_MORE; w.target = ST_SCAN_RD;
         end
         ST_TAIL: begin
            w.op = OP_TAIL;
         end
         ST_DONE: begin
            w.op = OP_DONE; w.last = 1'b1; w.cond = COND_ALWAYS; w.target = ST_FETCH;
         end
         ST_BS_EMPTY: begin
            w.cond = COND_EMPTY; w.target = ST_FETCH;
         end
         ST_BS_1: begin
            w.op = OP_DEC_EMIT; w.tx = CH_BS;
         end
         ST_BS_SP: begin
            w.op = OP_EMIT_CONST; w.tx = CH_SP;
         end
         ST_BS_2: begin
            w.op = OP_EMIT_CONST; w.tx = CH_BS; w.last = 1'b1;
            w.cond = COND_ALWAYS; w.target = ST_FETCH;
         end
         default: begin
            w.cond = COND_ALWAYS; w.target = ST_FETCH;
         end
      endcase
      return w;
   endfunction

endpackage

/* src/command_line_editor_tokenizer.sv */
// Command line editor with quoted argument split: top level, echo register on the
// APB-style port; instantiates cle_seq and cle_dp, uses cle_pkg.
// Accepts a new character only when the previous one is fully handled; the output
// register holds a result while rsp_stall is high. Reset: synchronous; empties line,
// echo enabled.
module command_line_editor_tokenizer
   import cle_pkg::*;
#(
   parameter int LINE_BUFFER_SIZE = LINE_BUFFER_SIZE_DEF,
   parameter int MAX_ARGS         = MAX_ARGS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_tx_char,
   output logic [2:0]  rsp_arg_index,
   output logic [5:0]  rsp_arg_start,
   output logic [5:0]  rsp_arg_length,
   output logic [3:0]  rsp_arg_count,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic REG_ECHO = 1'b0;

   logic      echo_ff, echo_in;
   ucode_type ctl;
   flag_type  flags;

   assign pready = 1'b1;

   always_comb begin
      echo_in = echo_ff;
      if (psel && penable && pwrite && (paddr[2] == REG_ECHO)) begin
         echo_in = pwdata[0];
      end
      prdata = (paddr[2] == REG_ECHO) ? {31'b0, echo_ff} : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_ff <= 1'b1;
      end else begin
         echo_ff <= echo_in;
      end
   end

   cle_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   cle_dp #(
      .LINE_BUFFER_SIZE (LINE_BUFFER_SIZE),
      .MAX_ARGS         (MAX_ARGS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .echo_enable    (echo_ff),
      .flags          (flags),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_char    (req_rx_char),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_tx_char    (rsp_tx_char),
      .rsp_arg_index  (rsp_arg_index),
      .rsp_arg_start  (rsp_arg_start),
      .rsp_arg_length (rsp_arg_length),
      .rsp_arg_count  (rsp_arg_count),
      .rsp_last       (rsp_last)
   );

endmodule

/* src/cle_seq.sv */
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// Depends on cle_pkg.
module cle_seq
   import cle_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  flag_type  flags,
   output ucode_type ctl
);

   logic [PC_W-1:0] pc_ff, pc_in;
   logic            take;

   assign ctl = ucode_rom(pc_ff);

   always_comb begin
      unique case (ctl.cond)
         COND_NEVER:    take = 1'b0;
         COND_ALWAYS:   take = 1'b1;
         COND_NO_REQ:   take = flags.no_req;
         COND_IS_CR:    take = flags.is_cr;
         COND_IS_BS:    take = flags.is_bs;
         COND_IS_LF:    take = flags.is_lf;
         COND_FULL:     take = flags.full;
         COND_ECHO_OFF: take = flags.echo_off;
         COND_EMPTY:    take = flags.empty;
         COND_AT_END:   take = flags.at_end;
         COND_MORE:     take = flags.more;
         default:       take = 1'b1;
      endcase
      if (flags.hold) begin
         pc_in = pc_ff;
      end else if (take) begin
         pc_in = ctl.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

/* src/cle_dp.sv */
// Datapath: line buffer memory, fill count, argument scanner registers
// and the result output register. Driven by the control word; uses cle_pkg.
module cle_dp
   import cle_pkg::*;
#(
   parameter int LINE_BUFFER_SIZE = LINE_BUFFER_SIZE_DEF,
   parameter int MAX_ARGS         = MAX_ARGS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  ucode_type  ctl,
   input  logic       echo_enable,
   output flag_type   flags,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_char,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_tx_char,
   output logic [2:0] rsp_arg_index,
   output logic [5:0] rsp_arg_start,
   output logic [5:0] rsp_arg_length,
   output logic [3:0] rsp_arg_count,
   output logic       rsp_last
);

   localparam int AW = $clog2(LINE_BUFFER_SIZE);
   localparam int CW = $clog2(MAX_ARGS + 1);

   logic [7:0]    mem [LINE_BUFFER_SIZE];
   logic [7:0]    rd_ff;

   logic [7:0]    char_ff, char_in;
   logic [AW-1:0] fill_ff, fill_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] start_ff, start_in;
   mode_type      mode_ff, mode_in;
   logic [CW-1:0] count_ff, count_in;

   logic          out_valid_ff, out_valid_in;
   kind_type      kind_ff, kind_in;
   logic [7:0]    tx_ff, tx_in;
   logic [2:0]    aidx_ff, aidx_in;
   logic [5:0]    astart_ff, astart_in;
   logic [5:0]    alen_ff, alen_in;
   logic [3:0]    acnt_ff, acnt_in;
   logic          last_ff, last_in;

   logic          accept, term, limit, emit_req, out_free, go, store_en;
   logic [CW:0]   count_inc;

   assign req_stall = (ctl.op != OP_FETCH);
   assign accept    = req_valid && !req_stall;

   assign term = ((mode_ff == MODE_WORD) && (rd_ff == CH_SP)) ||
                 ((mode_ff == MODE_QUOTE) && (rd_ff == CH_QUOTE));
   assign count_inc = {1'b0, count_ff} + 1'b1;
   assign limit     = term && (count_inc >= (CW+1)'(MAX_ARGS));

   always_comb begin
      unique case (ctl.op)
         OP_EMIT_CHAR, OP_EMIT_CONST, OP_DEC_EMIT, OP_DONE: emit_req = 1'b1;
         OP_SCAN: emit_req = term;
         OP_TAIL: emit_req = (mode_ff != MODE_SEEK);
         default: emit_req = 1'b0;
      endcase
   end

   assign out_free = !out_valid_ff || !rsp_stall;
   assign go       = !(emit_req && !out_free);
   assign store_en = go && (ctl.op == OP_STORE);

   always_comb begin
      flags.no_req   = !req_valid;
      flags.is_cr    = (char_ff == CH_CR);
      flags.is_bs    = (char_ff == CH_BS) || (char_ff == CH_DEL);
      flags.is_lf    = (char_ff == CH_LF);
      flags.full     = (fill_ff == AW'(LINE_BUFFER_SIZE - 1));
      flags.echo_off = !echo_enable;
      flags.empty    = (fill_ff == '0);
      flags.at_end   = (idx_ff == fill_ff);
      flags.more     = !limit;
      flags.hold     = !go;
   end

   // state updates
   always_comb begin
      char_in  = char_ff;
      fill_in  = fill_ff;
      idx_in   = idx_ff;
      start_in = start_ff;
      mode_in  = mode_ff;
      count_in = count_ff;
      if (go) begin
         unique case (ctl.op)
            OP_FETCH: begin
               if (accept) begin
                  char_in  = req_rx_char;
                  idx_in   = '0;
                  mode_in  = MODE_SEEK;
                  count_in = '0;
               end
            end
            OP_STORE:    fill_in = fill_ff + 1'b1;
            OP_DEC_EMIT: fill_in = fill_ff - 1'b1;
            OP_SCAN: begin
               idx_in = idx_ff + 1'b1;
               if (mode_ff == MODE_SEEK) begin
                  if (rd_ff == CH_QUOTE) begin
                     mode_in  = MODE_QUOTE;
                     start_in = idx_ff + 1'b1;
                  end else if (rd_ff != CH_SP) begin
                     mode_in  = MODE_WORD;
                     start_in = idx_ff;
                  end
               end else if (term) begin
                  mode_in  = MODE_SEEK;
                  count_in = count_inc[CW-1:0];
               end
            end
            OP_TAIL: begin
               if (mode_ff != MODE_SEEK) begin
                  count_in = count_inc[CW-1:0];
               end
            end
            OP_DONE: fill_in = '0;
            default: ;
         endcase
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      tx_in        = tx_ff;
      aidx_in      = aidx_ff;
      astart_in    = astart_ff;
      alen_in      = alen_ff;
      acnt_in      = acnt_ff;
      last_in      = last_ff;
      if (emit_req && out_free) begin
         out_valid_in = 1'b1;
         kind_in      = KIND_TX;
         tx_in        = CH_NUL;
         aidx_in      = '0;
         astart_in    = '0;
         alen_in      = '0;
         acnt_in      = '0;
         last_in      = ctl.last;
         unique case (ctl.op)
            OP_EMIT_CHAR: tx_in = char_ff;
            OP_SCAN: begin
               kind_in   = KIND_ARG;
               aidx_in   = 3'(count_ff);
               astart_in = 6'(start_ff);
               alen_in   = 6'(idx_ff - start_ff);
            end
            OP_TAIL: begin
               kind_in   = KIND_ARG;
               aidx_in   = 3'(count_ff);
               astart_in = 6'(start_ff);
               alen_in   = 6'(fill_ff - start_ff);
            end
            OP_DONE: begin
               kind_in = KIND_DONE;
               acnt_in = 4'(count_ff);
            end
            default: tx_in = ctl.tx;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         mem[fill_ff] <= char_ff;
      end
      rd_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
      char_ff   <= char_in;
      idx_ff    <= idx_in;
      start_ff  <= start_in;
      mode_ff   <= mode_in;
      count_ff  <= count_in;
      kind_ff   <= kind_in;
      tx_ff     <= tx_in;
      aidx_ff   <= aidx_in;
      astart_ff <= astart_in;
      alen_ff   <= alen_in;
      acnt_ff   <= acnt_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_tx_char    = tx_ff;
   assign rsp_arg_index  = aidx_ff;
   assign rsp_arg_start  = astart_ff;
   assign rsp_arg_length = alen_ff;
   assign rsp_arg_count  = acnt_ff;
   assign rsp_last       = last_ff;

endmodule

/* verif/tb_command_line_editor_tokenizer.sv */
// Testbench for command_line_editor_tokenizer: drives received characters and echo
// register writes, predicts echo, erase, argument descriptors and line-done markers.
// Depends on cle_pkg and the command_line_editor_tokenizer RTL only.
module tb_command_line_editor_tokenizer;
   import cle_pkg::*;

   localparam int          SETTLE_CYCLES  = 16;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          RANDOM_ITEMS   = 150;
   localparam logic [2:0]  ECHO_ADDR      = 3'd0;
   localparam logic [2:0]  SPARE_ADDR     = 3'd4;

   typedef struct {
      kind_type   kind;
      logic [7:0] tx_char;
      logic [2:0] arg_index;
      logic [5:0] arg_start;
      logic [5:0] arg_length;
      logic [3:0] arg_count;
      logic       last;
   } console_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_char = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_tx_char;
   logic [2:0]  rsp_arg_index;
   logic [5:0]  rsp_arg_start;
   logic [5:0]  rsp_arg_length;
   logic [3:0]  rsp_arg_count;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'h0;
   logic [31:0] prdata;
   logic        pready;

   console_result_type expected_results[$];
   logic [7:0]      line_mem [LINE_BUFFER_SIZE_DEF];
   int unsigned     line_fill = 0;
   logic            echo_on = 1'b1;
   int unsigned     send_gap_pct = 19;
   int unsigned     stall_pct = 81;
   int unsigned     sent_items = 0;
   int              mismatch_count = 0;
   int              idle_cycles = 0;

   always #5 clock = ~clock;

   command_line_editor_tokenizer i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_char    (req_rx_char),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_tx_char    (rsp_tx_char),
      .rsp_arg_index  (rsp_arg_index),
      .rsp_arg_start  (rsp_arg_start),
      .rsp_arg_length (rsp_arg_length),
      .rsp_arg_count  (rsp_arg_count),
      .rsp_last       (rsp_last),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   task automatic report_mismatch(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic void add_result(kind_type kind, logic [7:0] tx, int unsigned idx,
                                      int unsigned start, int unsigned len,
                                      int unsigned cnt);
      console_result_type r;
      r.kind       = kind;
      r.tx_char    = tx;
      r.arg_index  = idx[2:0];
      r.arg_start  = start[5:0];
      r.arg_length = len[5:0];
      r.arg_count  = cnt[3:0];
      r.last       = 1'b0;
      expected_results.push_back(r);
   endfunction

   // Line editor and argument splitter, one received character per call.
   function automatic void predict_editor(logic [7:0] c);
      int unsigned first_n;
      int unsigned found;
      int unsigned start;
      mode_type    mode;
      first_n = expected_results.size();
      if (c == CH_CR) begin
         found = 0;
         if (line_fill != 0) begin
            add_result(KIND_TX, CH_CR, 0, 0, 0, 0);
            add_result(KIND_TX, CH_LF, 0, 0, 0, 0);
            mode  = MODE_SEEK;
            start = 0;
            for (int unsigned i = 0; i < line_fill && found < MAX_ARGS_DEF; i++) begin
               if (mode == MODE_SEEK) begin
                  if (line_mem[i] == CH_QUOTE) begin
                     mode  = MODE_QUOTE;
                     start = i + 1;
                  end else if (line_mem[i] != CH_SP) begin
                     mode  = MODE_WORD;
                     start = i;
                  end
               end else if ((mode == MODE_WORD && line_mem[i] == CH_SP) ||
                            (mode == MODE_QUOTE && line_mem[i] == CH_QUOTE)) begin
                  add_result(KIND_ARG, CH_NUL, found, start, i - start, 0);
                  found++;
                  mode = MODE_SEEK;
               end
            end
            // unclosed quote or word running to the end of the line
            if (mode != MODE_SEEK) begin
               add_result(KIND_ARG, CH_NUL, found, start, line_fill - start, 0);
               found++;
            end
         end
         add_result(KIND_DONE, CH_NUL, 0, 0, 0, found);
         line_fill = 0;
      end else if (c == CH_DEL || c == CH_BS) begin
         if (line_fill != 0) begin
            line_fill--;
            add_result(KIND_TX, CH_BS, 0, 0, 0, 0);
            add_result(KIND_TX, CH_SP, 0, 0, 0, 0);
            add_result(KIND_TX, CH_BS, 0, 0, 0, 0);
         end
      end else if (c != CH_LF && line_fill < LINE_BUFFER_SIZE_DEF - 1) begin
         line_mem[line_fill] = c;
         line_fill++;
         if (echo_on) begin
            add_result(KIND_TX, c, 0, 0, 0, 0);
         end
      end
      if (expected_results.size() > first_n) begin
         expected_results[expected_results.size() - 1].last = 1'b1;
      end
   endfunction

   task automatic send_char(logic [7:0] c);
      if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_char <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_editor(c);
      if (c != CH_LF) begin
         sent_items++;
      end
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i]);
      end
   endtask

   // Any byte that is stored as an ordinary word character.
   function automatic logic [7:0] word_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(255));
      end while (b == CH_CR || b == CH_LF || b == CH_BS || b == CH_DEL ||
                 b == CH_SP || b == CH_QUOTE);
      return b;
   endfunction

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      wait_results_drained();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (addr == ECHO_ADDR) begin
         echo_on = data[0];
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic check_echo_readback();
      logic [31:0] rd;
      wait_results_drained();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ECHO_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      rd = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (rd !== {31'b0, echo_on}) begin
         report_mismatch($sformatf("echo register reads %08h, want %0b", rd, echo_on));
      end
   endtask

   task automatic test_register_access();
      check_echo_readback();
      csr_write(SPARE_ADDR, 32'h0);
      check_echo_readback();
      csr_write(ECHO_ADDR, 32'hFFFF_FFFE);
      check_echo_readback();
      csr_write(ECHO_ADDR, 32'h0000_0001);
      check_echo_readback();
   endtask

   task automatic test_line_editing();
      send_char(CH_CR);
      send_char(CH_BS);
      send_char(CH_DEL);
      send_char(CH_LF);
      send_char(8'h00);
      send_char(8'hFF);
      send_char(CH_BS);
      send_char(CH_DEL);
      // quote inside a word, quoted spaces, empty quotes, unclosed quote
      send_text("x\"y \"p q\" \"\" \"z");
      send_char(CH_CR);
   endtask

   task automatic test_echo_off();
      csr_write(ECHO_ADDR, 32'h0);
      send_text("ab \"c");
      send_char(CH_BS);
      send_char(CH_CR);
      csr_write(ECHO_ADDR, 32'h1);
   endtask

   task automatic test_buffer_full();
      repeat (70) send_char(word_byte());
      send_char(CH_CR);
      repeat (61) send_char(word_byte());
      send_char(CH_SP);
      send_char(CH_QUOTE);
      repeat (3) send_char(word_byte());
      send_char(CH_DEL);
      send_char(CH_QUOTE);
      send_char(CH_CR);
   endtask

   task automatic test_argument_limit();
      send_text("a b c d e f g h i j");
      send_char(CH_CR);
      send_text(" \"1 2\" b c d e f g hh");
      send_char(CH_CR);
   endtask

   // Mostly well-formed lines with random words; some noise and broken quoting.
   task automatic test_random_lines(int unsigned n);
      int unsigned stop_at;
      int unsigned pause_at;
      int unsigned shape;
      int unsigned style;
      bit          paused;
      stop_at  = sent_items + n;
      pause_at = sent_items + n / 2;
      paused   = 1'b0;
      while (sent_items < stop_at) begin
         if (!paused && sent_items >= pause_at) begin
            wait_results_drained();
            paused = 1'b1;
         end
         shape = $urandom_range(99);
         if (shape < 10) begin
            repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(255)));
         end else if (shape < 14) begin
            repeat ($urandom_range(55, 70)) begin
               send_char($urandom_range(5) == 0 ? CH_SP : word_byte());
            end
            send_char(CH_CR);
         end else begin
            repeat ($urandom_range(0, 10)) begin
               repeat ($urandom_range(1, 2)) send_char(CH_SP);
               style = $urandom_range(9);
               if (style < 3) begin
                  send_char(CH_QUOTE);
                  repeat ($urandom_range(0, 5)) begin
                     send_char($urandom_range(3) == 0 ? CH_SP : word_byte());
                  end
                  if (style != 0) begin
                     send_char(CH_QUOTE);
                  end
               end else begin
                  repeat ($urandom_range(1, 6)) send_char(word_byte());
                  if (style == 9) begin
                     send_char(CH_QUOTE);
                  end else if (style == 8) begin
                     send_char($urandom_range(1) ? CH_BS : CH_DEL);
                  end
               end
            end
            if ($urandom_range(9) == 0) begin
               send_char(CH_LF);
            end
            send_char(CH_CR);
         end
      end
   endtask

   always @(posedge clock) begin : result_check
      console_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction: kind %0d tx %02h",
                                         rsp_kind, rsp_tx_char));
            end else begin
               want = expected_results.pop_front();
               if (rsp_kind !== want.kind || rsp_tx_char !== want.tx_char ||
                   rsp_arg_index !== want.arg_index || rsp_arg_start !== want.arg_start ||
                   rsp_arg_length !== want.arg_length || rsp_arg_count !== want.arg_count ||
                   rsp_last !== want.last) begin
                  report_mismatch({
                     $sformatf("got k%0d tx %02h i%0d s%0d l%0d n%0d last %0b, ",
                               rsp_kind, rsp_tx_char, rsp_arg_index, rsp_arg_start,
                               rsp_arg_length, rsp_arg_count, rsp_last),
                     $sformatf("want k%0d tx %02h i%0d s%0d l%0d n%0d last %0b",
                               want.kind, want.tx_char, want.arg_index, want.arg_start,
                               want.arg_length, want.arg_count, want.last)});
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("** command_line_editor_tokenizer: FAILED **");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_access();
      test_line_editing();
      test_echo_off();
      test_buffer_full();
      test_argument_limit();
      test_random_lines(RANDOM_ITEMS / 3);
      csr_write(ECHO_ADDR, 32'h0);
      send_gap_pct = 81;
      stall_pct    = 19;
      test_random_lines(RANDOM_ITEMS / 3);
      csr_write(ECHO_ADDR, 32'h1);
      send_gap_pct = 0;
      stall_pct    = 0;
      test_random_lines(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
      wait_results_drained();
      if (mismatch_count == 0) begin
         $display("** command_line_editor_tokenizer: PASSED **");
      end else begin
         $display("** command_line_editor_tokenizer: FAILED **");
      end
      $finish;
   end

endmodule
